// ===== rtl/bctp_pkg.sv =====
// Shared types and constants for the battery-compensated throttle to PWM block.
// Holds the port widths, register indexes, microcode field codes and the control ROM.
// No dependencies; every other file imports this package.
package bctp_pkg;

  // Port and field widths.
  localparam int THR_W       = 16;
  localparam int MV_W        = 16;
  localparam int PW_W        = 11;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 3;

  // Voltage fraction in Q1.16 (0 .. 65536) and its divider.
  localparam int FRAC_W    = 17;
  localparam int DIV_STEPS = 17;
  localparam int CNT_W     = 5;

  // Fixed-point alignment of the quadratic sum.
  localparam int C2_SHIFT  = 30;
  localparam int C1_SHIFT  = 15;
  localparam int ACC_SHIFT = 42;
  localparam int INT_FRAC  = 8;

  localparam int PULSE_MIN     = 1000;
  localparam int PULSE_MAX     = 2000;
  localparam int PULSE_NEUTRAL = 1500;

  // Opcodes carried in tuser.
  localparam logic OP_THROTTLE = 1'b0;
  localparam logic OP_BATTERY  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VLOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VHIGH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_LO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_HI   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BWD_LO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BWD_HI   = 3'd6;

  // Multiplier operand selection.
  localparam logic [1:0] M_XX = 2'd0;  // x * x
  localparam logic [1:0] M_DT = 2'd1;  // (c_high - c_low) * t
  localparam logic [1:0] M_CX = 2'd2;  // ci * x
  localparam logic [1:0] M_CQ = 2'd3;  // ci * x^2

  // Coefficient index within a packed set.
  localparam logic [1:0] K_C0 = 2'd0;
  localparam logic [1:0] K_C1 = 2'd1;
  localparam logic [1:0] K_C2 = 2'd2;

  // Accumulator operations.
  localparam logic [2:0] A_NONE  = 3'd0;
  localparam logic [2:0] A_LDC2  = 3'd1;
  localparam logic [2:0] A_ADD15 = 3'd2;
  localparam logic [2:0] A_ADDP  = 3'd3;
  localparam logic [2:0] A_BIAS  = 3'd4;

  // Pulse register operations.
  localparam logic [1:0] P_NONE    = 2'd0;
  localparam logic [1:0] P_SAT     = 2'd1;
  localparam logic [1:0] P_NEUTRAL = 2'd2;

  // Divider operations.
  localparam logic [1:0] D_NONE  = 2'd0;
  localparam logic [1:0] D_INIT  = 2'd1;
  localparam logic [1:0] D_STEP  = 2'd2;
  localparam logic [1:0] D_STORE = 2'd3;

  // Jump conditions.
  localparam logic [2:0] C_NEXT   = 3'd0;
  localparam logic [2:0] C_ALWAYS = 3'd1;
  localparam logic [2:0] C_BAT    = 3'd2;
  localparam logic [2:0] C_DEAD   = 3'd3;
  localparam logic [2:0] C_CNT    = 3'd4;

  // Program addresses.
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] ST_IDLE     = 5'd0;
  localparam logic [STEP_W-1:0] ST_DISPATCH = 5'd1;
  localparam logic [STEP_W-1:0] ST_DEADZONE = 5'd2;
  localparam logic [STEP_W-1:0] ST_CI2      = 5'd3;
  localparam logic [STEP_W-1:0] ST_ACC2     = 5'd4;
  localparam logic [STEP_W-1:0] ST_CI1      = 5'd5;
  localparam logic [STEP_W-1:0] ST_MUL1     = 5'd6;
  localparam logic [STEP_W-1:0] ST_ACC1     = 5'd7;
  localparam logic [STEP_W-1:0] ST_CI0      = 5'd8;
  localparam logic [STEP_W-1:0] ST_MUL0     = 5'd9;
  localparam logic [STEP_W-1:0] ST_ACC0     = 5'd10;
  localparam logic [STEP_W-1:0] ST_ROUND    = 5'd11;
  localparam logic [STEP_W-1:0] ST_SAT      = 5'd12;
  localparam logic [STEP_W-1:0] ST_NEUTRAL  = 5'd13;
  localparam logic [STEP_W-1:0] ST_EMIT     = 5'd14;
  localparam logic [STEP_W-1:0] ST_BAT      = 5'd16;
  localparam logic [STEP_W-1:0] ST_DIV      = 5'd17;
  localparam logic [STEP_W-1:0] ST_STORE    = 5'd18;

  typedef struct packed {
    logic [1:0]        mul_sel;
    logic [1:0]        k;
    logic              x2_ld;
    logic              ci_ld;
    logic [2:0]        acc_op;
    logic [1:0]        pw_op;
    logic [1:0]        div_op;
    logic              wait_in;
    logic              wait_out;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
  } ctl_word_t;

  // Control program. A word whose condition holds jumps to its target,
  // otherwise the step counter advances by one.
  function automatic ctl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctl_word_t w;
    w = '0;
    case (step)
      ST_IDLE: begin
        w.wait_in = 1'b1;
      end
      ST_DISPATCH: begin
        w.mul_sel = M_XX;
        w.cond    = C_BAT;
        w.target  = ST_BAT;
      end
      ST_DEADZONE: begin
        w.x2_ld   = 1'b1;
        w.mul_sel = M_DT;
        w.k       = K_C2;
        w.cond    = C_DEAD;
        w.target  = ST_NEUTRAL;
      end
      ST_CI2: begin
        w.ci_ld = 1'b1;
        w.k     = K_C2;
      end
      ST_ACC2: begin
        w.acc_op  = A_LDC2;
        w.mul_sel = M_DT;
        w.k       = K_C1;
      end
      ST_CI1: begin
        w.ci_ld = 1'b1;
        w.k     = K_C1;
      end
      ST_MUL1: begin
        w.mul_sel = M_CX;
      end
      ST_ACC1: begin
        w.acc_op  = A_ADD15;
        w.mul_sel = M_DT;
        w.k       = K_C0;
      end
      ST_CI0: begin
        w.ci_ld = 1'b1;
        w.k     = K_C0;
      end
      ST_MUL0: begin
        w.mul_sel = M_CQ;
      end
      ST_ACC0: begin
        w.acc_op = A_ADDP;
      end
      ST_ROUND: begin
        w.acc_op = A_BIAS;
      end
      ST_SAT: begin
        w.pw_op  = P_SAT;
        w.cond   = C_ALWAYS;
        w.target = ST_EMIT;
      end
      ST_NEUTRAL: begin
        w.pw_op = P_NEUTRAL;
      end
      ST_EMIT: begin
        w.wait_out = 1'b1;
        w.cond     = C_ALWAYS;
        w.target   = ST_IDLE;
      end
      ST_BAT: begin
        w.div_op = D_INIT;
      end
      ST_DIV: begin
        w.div_op = D_STEP;
        w.cond   = C_CNT;
        w.target = ST_DIV;
      end
      ST_STORE: begin
        w.div_op = D_STORE;
        w.cond   = C_ALWAYS;
        w.target = ST_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/battery_compensated_throttle_to_pwm.sv =====
// Top level: throttle to ESC pulse width with battery-voltage coefficient interpolation.
// A microcoded sequencer drives one shared multiplier, an accumulator and a bit-serial divider.
// Depends on bctp_pkg for widths, codes and the control ROM.
//
// Usage:
//   Input words arrive on in_tvalid/in_tready with in_tdata (throttle, battery_mv) and
//   in_tuser (opcode). Opcode 1 updates the stored battery fraction and returns no word;
//   opcode 0 converts a throttle into one pulse-width word on out_tvalid/out_tready.
//   Configuration words are written on cfg_valid/cfg_ready with cfg_index and cfg_data;
//   the user writes them only while the block is idle, which the block does not enforce;
//   cfg_ready is always high and unknown indexes are ignored.
// Sequence:
//   A throttle word runs dispatch, the deadzone test, three interpolations, the curve terms,
//   rounding, saturation and emit before the next word is taken; inside the deadzone it goes
//   straight to the neutral pulse and emit. A battery word runs the divider and stores
//   the fraction before the next word. One shared multiplier serves the square, the three
//   interpolations and two curve terms; the divider retires one quotient bit per cycle.
// Reset and stalls:
//   rst_n clears the sequencer, the output register and the configuration registers to
//   their defaults (upper calibration voltage 65535) and the stored fraction to zero.
//   A finished pulse width sits in a one-word output register. If the receiver stalls,
//   that word holds steady; the next throttle is still accepted and computed, and only
//   its final emit step waits until the output register is free.

module battery_compensated_throttle_to_pwm
  import bctp_pkg::*;
#(
  parameter int COEFF_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_TDATA_W-1:0]    in_tdata,   // [15:0] throttle, [31:16] battery_mv
  input  logic [IN_TUSER_W-1:0]    in_tuser,   // [0] opcode
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_TDATA_W-1:0]   out_tdata,  // [10:0] pulse_width, [15:11] zero
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [3*COEFF_WIDTH-1:0] cfg_data
);

  // Derived widths. Interpolated coefficients carry 12 fractional bits and stay
  // within the range of the two calibration values, so CW + 8 bits hold them.
  localparam int CW    = COEFF_WIDTH;
  localparam int SET_W = 3 * CW;
  localparam int CIW   = CW + INT_FRAC;
  localparam int DT_W  = CW + 18;
  localparam int MB_W  = 32;
  localparam int P_W   = CIW + MB_W;
  localparam int ACC_W = CW + ACC_SHIFT;
  localparam int Q_W   = ACC_W - ACC_SHIFT;
  localparam logic [ACC_W-1:0] RND_BIAS = {{(ACC_W-ACC_SHIFT){1'b0}}, {ACC_SHIFT{1'b1}}};
  localparam logic [DT_W-1:0]  DT_BIAS  = {{(DT_W-INT_FRAC){1'b0}}, {INT_FRAC{1'b1}}};

  // Sequencer.
  logic [STEP_W-1:0] pc_r, pc_nxt;
  ctl_word_t         w;
  logic              jump;
  logic              stall;
  logic              in_acc;
  logic              out_busy;
  logic              out_load;

  // Configuration registers.
  logic [MV_W-1:0]  dz_r, vlo_r, vhi_r;
  logic [SET_W-1:0] fwd_lo_r, fwd_hi_r, bwd_lo_r, bwd_hi_r;

  // Stored battery fraction and the captured input word.
  logic [FRAC_W-1:0]       t_r;
  logic                    op_r;
  logic signed [THR_W-1:0] x_r;
  logic [MV_W-1:0]         bat_r;

  // Datapath registers.
  logic signed [MB_W-1:0]  x2_r;
  logic signed [P_W-1:0]   prod_r;
  logic signed [CIW-1:0]   ci_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [PW_W-1:0]         pw_r;

  // Divider registers.
  logic [FRAC_W-1:0] rem_r, q_r;
  logic [MV_W-1:0]   den_r;
  logic [CNT_W-1:0]  cnt_r;

  // Output register.
  logic            out_valid_r;
  logic [PW_W-1:0] out_pw_r;

  // Combinational datapath signals.
  logic [SET_W-1:0]        lo_set, hi_set;
  logic signed [CW-1:0]    cl, ch;
  logic signed [CW:0]      d;
  logic signed [CIW-1:0]   mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [MB_W-1:0]  x_ext;
  logic signed [DT_W-1:0]  pdt, pdt_adj, tq, cl_w, ci_wide;
  logic signed [ACC_W-1:0] ci_acc, prod_acc;
  logic signed [Q_W-1:0]   q;
  logic signed [31:0]      q_ext;
  logic [PW_W-1:0]         pw_sat;
  logic [THR_W:0]          ax;
  logic                    dead;
  logic [MV_W-1:0]         v_up, v_clamp;
  logic [FRAC_W-1:0]       den_ext;
  logic                    div_ge;
  logic [FRAC_W-1:0]       div_diff;

  assign w = ucode_rom(pc_r);

  // Handshakes. The block takes a word only at the idle step; the emit step
  // waits while the output register still holds an untaken word.
  assign in_tready  = w.wait_in;
  assign in_acc     = in_tvalid & w.wait_in;
  assign out_busy   = out_valid_r & ~out_tready;
  assign out_load   = w.wait_out & ~out_busy;
  assign stall      = (w.wait_in & ~in_tvalid) | (w.wait_out & out_busy);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-PW_W){1'b0}}, out_pw_r};
  assign cfg_ready  = 1'b1;

  // Deadzone test on the magnitude, which needs one extra bit for -32768.
  assign ax   = x_r[THR_W-1] ? ((THR_W+1)'(0) - {x_r[THR_W-1], x_r}) : {1'b0, x_r};
  assign dead = ax < {1'b0, dz_r};

  always_comb begin
    case (w.cond)
      C_NEXT:   jump = 1'b0;
      C_ALWAYS: jump = 1'b1;
      C_BAT:    jump = (op_r == OP_BATTERY);
      C_DEAD:   jump = dead;
      C_CNT:    jump = (cnt_r != '0);
      default:  jump = 1'b0;
    endcase
    if (stall) begin
      pc_nxt = pc_r;
    end else if (jump) begin
      pc_nxt = w.target;
    end else begin
      pc_nxt = pc_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // Configuration writes; indexes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r     <= '0;
      vlo_r    <= '0;
      vhi_r    <= '1;
      fwd_lo_r <= '0;
      fwd_hi_r <= '0;
      bwd_lo_r <= '0;
      bwd_hi_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEADZONE: dz_r     <= cfg_data[MV_W-1:0];
        REG_VLOW:     vlo_r    <= cfg_data[MV_W-1:0];
        REG_VHIGH:    vhi_r    <= cfg_data[MV_W-1:0];
        REG_FWD_LO:   fwd_lo_r <= cfg_data;
        REG_FWD_HI:   fwd_hi_r <= cfg_data;
        REG_BWD_LO:   bwd_lo_r <= cfg_data;
        REG_BWD_HI:   bwd_hi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_tuser[0];
      x_r   <= in_tdata[THR_W-1:0];
      bat_r <= in_tdata[THR_W+MV_W-1:THR_W];
    end
  end

  // Coefficient selection: the backward set serves negative throttle.
  assign lo_set = x_r[THR_W-1] ? bwd_lo_r : fwd_lo_r;
  assign hi_set = x_r[THR_W-1] ? bwd_hi_r : fwd_hi_r;

  always_comb begin
    case (w.k)
      K_C0: begin
        cl = lo_set[CW-1:0];
        ch = hi_set[CW-1:0];
      end
      K_C1: begin
        cl = lo_set[2*CW-1:CW];
        ch = hi_set[2*CW-1:CW];
      end
      K_C2: begin
        cl = lo_set[3*CW-1:2*CW];
        ch = hi_set[3*CW-1:2*CW];
      end
      default: begin
        cl = lo_set[CW-1:0];
        ch = hi_set[CW-1:0];
      end
    endcase
  end

  assign d     = {ch[CW-1], ch} - {cl[CW-1], cl};
  assign x_ext = {{(MB_W-THR_W){x_r[THR_W-1]}}, x_r};

  // Shared multiplier operands.
  always_comb begin
    case (w.mul_sel)
      M_XX: begin
        mul_a = {{(CIW-THR_W){x_r[THR_W-1]}}, x_r};
        mul_b = x_ext;
      end
      M_DT: begin
        mul_a = {{(CIW-CW-1){d[CW]}}, d};
        mul_b = {{(MB_W-FRAC_W){1'b0}}, t_r};
      end
      M_CX: begin
        mul_a = ci_r;
        mul_b = x_ext;
      end
      M_CQ: begin
        mul_a = ci_r;
        mul_b = x2_r;
      end
      default: begin
        mul_a = {{(CIW-THR_W){x_r[THR_W-1]}}, x_r};
        mul_b = x_ext;
      end
    endcase
  end

  // Interpolation: c_low * 256 plus (c_high - c_low) * t / 256 rounded toward zero.
  assign pdt     = prod_r[DT_W-1:0];
  assign pdt_adj = pdt + (pdt[DT_W-1] ? DT_BIAS : '0);
  assign tq      = pdt_adj >>> INT_FRAC;
  assign cl_w    = {{(DT_W-CW){cl[CW-1]}}, cl};
  assign ci_wide = (cl_w <<< INT_FRAC) + tq;

  // Accumulator operands aligned to 42 fractional bits.
  assign ci_acc   = {{(ACC_W-CIW){ci_r[CIW-1]}}, ci_r};
  assign prod_acc = {{(ACC_W-P_W){prod_r[P_W-1]}}, prod_r};

  // After the rounding bias, an arithmetic shift truncates toward zero.
  assign q     = acc_r[ACC_W-1:ACC_SHIFT];
  assign q_ext = {{(32-Q_W){q[Q_W-1]}}, q};

  always_comb begin
    if (q_ext < PULSE_MIN) begin
      pw_sat = PW_W'(PULSE_MIN);
    end else if (q_ext > PULSE_MAX) begin
      pw_sat = PW_W'(PULSE_MAX);
    end else begin
      pw_sat = q_ext[PW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (w.x2_ld) begin
      x2_r <= prod_r[MB_W-1:0];
    end
    if (w.ci_ld) begin
      ci_r <= ci_wide[CIW-1:0];
    end
    case (w.acc_op)
      A_LDC2:  acc_r <= ci_acc <<< C2_SHIFT;
      A_ADD15: acc_r <= acc_r + (prod_acc <<< C1_SHIFT);
      A_ADDP:  acc_r <= acc_r + prod_acc;
      A_BIAS:  acc_r <= acc_r + (acc_r[ACC_W-1] ? RND_BIAS : '0);
      default: ;
    endcase
    case (w.pw_op)
      P_SAT:     pw_r <= pw_sat;
      P_NEUTRAL: pw_r <= PW_W'(PULSE_NEUTRAL);
      default: ;
    endcase
  end

  // Battery fraction: clamp to the calibrated range, then restoring division
  // of (v - low) * 2^16 by (high - low), one quotient bit per cycle.
  assign v_up     = (bat_r < vlo_r) ? vlo_r : bat_r;
  assign v_clamp  = (v_up > vhi_r) ? vhi_r : v_up;
  assign den_ext  = {1'b0, den_r};
  assign div_ge   = rem_r >= den_ext;
  assign div_diff = div_ge ? (rem_r - den_ext) : rem_r;

  always_ff @(posedge clk) begin
    case (w.div_op)
      D_INIT: begin
        rem_r <= {1'b0, v_clamp - vlo_r};
        den_r <= vhi_r - vlo_r;
        q_r   <= '0;
        cnt_r <= CNT_W'(DIV_STEPS - 1);
      end
      D_STEP: begin
        rem_r <= {div_diff[FRAC_W-2:0], 1'b0};
        q_r   <= {q_r[FRAC_W-2:0], div_ge};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      default: ;
    endcase
  end

  // The fraction is zero when the calibration voltages are equal or inverted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r <= '0;
    end else if (w.div_op == D_STORE) begin
      t_r <= (vhi_r > vlo_r) ? q_r : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pw_r <= pw_r;
    end
  end

endmodule

// ===== rtl/bctp_checker.sv =====
// Port-level checker for battery_compensated_throttle_to_pwm, bound to the top level.
// Watches reset state, output stalls, the pulse range and single-word occupancy.
// Depends on bctp_pkg for widths and pulse limits.
module bctp_checker
  import bctp_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // Reset leaves no result pending and the block ready for a word.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Every result is a saturated pulse width.
  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata >= PULSE_MIN && out_tdata <= PULSE_MAX)
    else $error("pulse width out of range");

  // The block works on one word at a time.
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while busy");

endmodule

bind battery_compensated_throttle_to_pwm bctp_checker u_bctp_checker (.*);

// ===== test/battery_compensated_throttle_to_pwm_test.sv =====
// Self-checking testbench for battery_compensated_throttle_to_pwm.
// Drives throttle and battery words, predicts each pulse width in its own model and
// checks every result word in order; depends only on bctp_pkg and the block itself.
`timescale 1ns / 1ps

module battery_compensated_throttle_to_pwm_test
  import bctp_pkg::*;
();

  localparam int CW           = 16;      // coefficient width the block is built with
  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 40;      // long enough for any running battery word to finish
  localparam int LONG_STALL   = 300;     // receiver hold-off used to back the block up
  localparam int CHUNK_ITEMS  = 72;      // random words between two register settings
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Clock, reset and every block input start at known values.
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // [15:0] throttle, [31:16] battery_mv
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;  // [0] opcode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [10:0] pulse_width, [15:11] zero
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [3*CW-1:0]        cfg_data   = '0;

  // Our own copy of the configuration and of the stored battery fraction.
  logic [15:0]     cur_deadzone = 16'd0;
  logic [MV_W-1:0] cur_vlow     = 16'd0;
  logic [MV_W-1:0] cur_vhigh    = 16'd65535;
  logic [3*CW-1:0] cur_fwd_lo   = '0;
  logic [3*CW-1:0] cur_fwd_hi   = '0;
  logic [3*CW-1:0] cur_bwd_lo   = '0;
  logic [3*CW-1:0] cur_bwd_hi   = '0;
  logic [FRAC_W-1:0] cur_fraction = '0;

  // Pulse widths predicted for accepted throttle words, oldest first.
  logic [PW_W-1:0] pulses_due[$];
  logic [PW_W-1:0] pulse_want;

  int failures        = 0;
  int words_sent      = 0;
  int pulses_checked  = 0;
  int settings_used   = 0;
  int cycle_count     = 0;
  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int stall_requests  = 0;
  int stall_served    = 0;
  int stall_left      = 0;

  battery_compensated_throttle_to_pwm #(
    .COEFF_WIDTH(CW)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs or drops a word.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results still due",
               cycle_count, pulses_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver. A new stall request from the test makes it hold out_tready low for a
  // long stretch; otherwise it stalls at random with the current idle percentage.
  always @(posedge clk) begin
    if (stall_served != stall_requests) begin
      stall_served <= stall_requests;
      stall_left   <= LONG_STALL;
      out_tready   <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every accepted result word is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pulses_due.size() == 0) begin
        $error("pulse_width: no result expected, actual %0d", out_tdata[PW_W-1:0]);
        failures++;
      end else begin
        pulse_want = pulses_due.pop_front();
        pulses_checked++;
        if (out_tdata[PW_W-1:0] !== pulse_want) begin
          $error("pulse_width: expected %0d, actual %0d", pulse_want, out_tdata[PW_W-1:0]);
          failures++;
        end
      end
    end
  end

  // Signed coefficient k of a packed set, c0 in the lowest bits.
  function automatic longint coeff_at(input logic [3*CW-1:0] set, input int k);
    logic signed [CW-1:0] raw;
    raw = set[k*CW +: CW];
    return longint'(raw);
  endfunction

  // Coefficient blended between the low and high voltage sets by the stored fraction.
  // The result carries 12 fractional bits; the division truncates toward zero.
  function automatic longint blended_coeff(input logic [3*CW-1:0] lo_set,
                                           input logic [3*CW-1:0] hi_set, input int k);
    longint c_lo;
    longint c_hi;
    longint delta;
    c_lo  = coeff_at(lo_set, k);
    c_hi  = coeff_at(hi_set, k);
    delta = (c_hi - c_lo) * longint'(cur_fraction);
    return c_lo * 256 + delta / 256;
  endfunction

  function automatic logic [PW_W-1:0] expected_pulse(input logic [THR_W-1:0] thr);
    longint x;
    longint mag;
    longint c0;
    longint c1;
    longint c2;
    longint sum;
    longint pw;
    logic [3*CW-1:0] lo_set;
    logic [3*CW-1:0] hi_set;
    x   = longint'($signed(thr));
    mag = (x < 0) ? -x : x;
    if (mag < longint'(cur_deadzone)) return PW_W'(PULSE_NEUTRAL);
    lo_set = (x >= 0) ? cur_fwd_lo : cur_bwd_lo;
    hi_set = (x >= 0) ? cur_fwd_hi : cur_bwd_hi;
    c0  = blended_coeff(lo_set, hi_set, 0);
    c1  = blended_coeff(lo_set, hi_set, 1);
    c2  = blended_coeff(lo_set, hi_set, 2);
    // All three terms are aligned to 42 fractional bits before the sum.
    sum = c0 * (x * x) + ((c1 * x) <<< C1_SHIFT) + (c2 <<< C2_SHIFT);
    pw  = sum / (longint'(1) <<< ACC_SHIFT);
    if (pw < PULSE_MIN) pw = PULSE_MIN;
    if (pw > PULSE_MAX) pw = PULSE_MAX;
    return PW_W'(pw);
  endfunction

  // A battery word clamps the reading into the calibrated range and stores its
  // position in that range as a Q1.16 fraction; a degenerate range gives zero.
  function automatic void track_battery(input logic [MV_W-1:0] mv);
    longint v;
    longint span;
    v = longint'(mv);
    if (v < longint'(cur_vlow)) v = longint'(cur_vlow);
    if (v > longint'(cur_vhigh)) v = longint'(cur_vhigh);
    span = longint'(cur_vhigh) - longint'(cur_vlow);
    if (span > 0) cur_fraction = FRAC_W'(((v - longint'(cur_vlow)) <<< 16) / span);
    else cur_fraction = '0;
  endfunction

  function automatic logic [3*CW-1:0] pack_curve(input int c0, input int c1, input int c2);
    return {CW'(c2), CW'(c1), CW'(c0)};
  endfunction

  function automatic logic [3*CW-1:0] any_bits();
    return (3*CW)'({$urandom, $urandom});
  endfunction

  // Mostly a plausible thrust curve around neutral, sometimes arbitrary bits.
  function automatic logic [3*CW-1:0] curve_coeffs();
    if ($urandom_range(3) == 0) return any_bits();
    return pack_curve(int'($urandom_range(6000)) - 3000,
                      int'($urandom_range(16000)) - 8000,
                      24000 + int'($urandom_range(3200)) - 1600);
  endfunction

  // Writes one register while the block is idle and mirrors it into the model.
  // Bits above a register's width are dropped, an unused index changes nothing.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [3*CW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DEADZONE: cur_deadzone = value[15:0];
      REG_VLOW:     cur_vlow     = value[MV_W-1:0];
      REG_VHIGH:    cur_vhigh    = value[MV_W-1:0];
      REG_FWD_LO:   cur_fwd_lo   = value;
      REG_FWD_HI:   cur_fwd_hi   = value;
      REG_BWD_LO:   cur_bwd_lo   = value;
      REG_BWD_HI:   cur_bwd_hi   = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one input word, idling first at random, and predicts its effect once
  // the word is accepted. tvalid stays high when the next word follows at once.
  task automatic send_word(input logic op, input logic [THR_W-1:0] thr,
                           input logic [MV_W-1:0] mv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {mv, thr};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    if (op == OP_BATTERY) track_battery(mv);
    else pulses_due.push_back(expected_pulse(thr));
  endtask

  // The unused field of each word carries random bits.
  task automatic send_throttle(input int x);
    send_word(OP_THROTTLE, THR_W'(x), MV_W'($urandom));
  endtask

  task automatic send_battery(input int mv);
    send_word(OP_BATTERY, THR_W'($urandom), MV_W'(mv));
  endtask

  // Stops sending and waits until every predicted result has arrived, then lets the
  // block finish any battery word that is still running.
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pulses_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_word();
    int pick;
    int x;
    pick = $urandom_range(99);
    if (pick < 20) begin
      if (cur_vhigh > cur_vlow && $urandom_range(3) != 0)
        send_battery($urandom_range(cur_vhigh, cur_vlow));
      else
        send_battery($urandom_range(65535));
    end else begin
      pick = $urandom_range(9);
      if (pick < 4) begin
        x = $urandom_range(65535);
      end else if (pick < 6) begin
        // Around the deadzone edge on either side of zero.
        x = int'(cur_deadzone) + int'($urandom_range(6)) - 3;
        if ($urandom_range(1) == 1) x = -x;
      end else if (pick < 7) begin
        case ($urandom_range(4))
          0: x = -32768;
          1: x = 32767;
          2: x = 0;
          3: x = -1;
          default: x = 1;
        endcase
      end else begin
        x = int'($urandom_range(4000)) - 2000;
      end
      send_throttle(x);
    end
  endtask

  // New random values for every register, taken only once the block is idle.
  task automatic random_settings();
    int lo_mv;
    int hi_mv;
    int pick;
    wait_drain();
    settings_used++;
    case ($urandom_range(5))
      0: write_register(REG_DEADZONE, '0);
      1: write_register(REG_DEADZONE, (3*CW)'(32768));
      2: write_register(REG_DEADZONE, any_bits());
      default: write_register(REG_DEADZONE, (3*CW)'($urandom_range(1500)));
    endcase
    pick  = $urandom_range(9);
    lo_mv = $urandom_range(13000, 9000);
    hi_mv = lo_mv + int'($urandom_range(8000, 1));
    if (pick == 0) begin
      hi_mv = lo_mv;
    end else if (pick == 1) begin
      hi_mv = lo_mv - int'($urandom_range(3000, 1));
    end else if (pick == 2) begin
      lo_mv = 0;
      hi_mv = 65535;
    end else if (pick == 3) begin
      lo_mv = $urandom_range(65535);
      hi_mv = $urandom_range(65535);
    end
    write_register(REG_VLOW, (3*CW)'(lo_mv));
    write_register(REG_VHIGH, (3*CW)'(hi_mv));
    write_register(REG_FWD_LO, curve_coeffs());
    write_register(REG_FWD_HI, curve_coeffs());
    write_register(REG_BWD_LO, curve_coeffs());
    write_register(REG_BWD_HI, curve_coeffs());
    if ($urandom_range(3) == 0) write_register(REG_UNUSED, any_bits());
  endtask

  // Out of reset all coefficients are zero, so every throttle saturates low.
  task automatic test_reset_values();
    send_idle_pct = 20;
    recv_idle_pct = 84;
    send_throttle(0);
    send_throttle(-32768);
  endtask

  // Hand-picked words for the corners of the field ranges and the special cases.
  task automatic test_directed_cases();
    wait_drain();
    settings_used++;
    // Upper data bits of the narrow registers must be dropped.
    write_register(REG_DEADZONE, 48'hA5A5_5A5A_0200);
    write_register(REG_VLOW, {32'hFFFF_0000, 16'd12000});
    write_register(REG_VHIGH, (3*CW)'(16800));
    write_register(REG_FWD_LO, pack_curve(1600, 6400, 24000));
    write_register(REG_FWD_HI, pack_curve(960, 4800, 24000));
    write_register(REG_BWD_LO, pack_curve(-1440, 6080, 24000));
    write_register(REG_BWD_HI, pack_curve(-800, 4480, 24000));
    write_register(REG_UNUSED, any_bits());

    // Fraction zero, full scale both ways and both sides of the deadzone edge.
    send_battery(12000);
    send_throttle(32767);
    send_throttle(-32768);
    send_throttle(511);
    send_throttle(512);
    send_throttle(-512);
    send_throttle(0);
    // Fraction one, then readings clamped at either end, then a middle reading.
    send_battery(16800);
    send_throttle(32767);
    send_battery(65535);
    send_throttle(16384);
    send_battery(0);
    send_throttle(-16384);
    send_battery(14400);
    send_throttle(20000);

    // Moving the calibration alone must not change the stored fraction.
    wait_drain();
    write_register(REG_VHIGH, (3*CW)'(20000));
    send_throttle(20000);

    // Equal calibration voltages, and a zero deadzone with throttle zero going forward.
    wait_drain();
    write_register(REG_VLOW, (3*CW)'(15000));
    write_register(REG_VHIGH, (3*CW)'(15000));
    write_register(REG_DEADZONE, '0);
    send_battery(15000);
    send_throttle(0);

    // Inverted calibration voltages.
    wait_drain();
    write_register(REG_VLOW, (3*CW)'(17000));
    write_register(REG_VHIGH, (3*CW)'(13000));
    send_battery(14000);
    send_throttle(-1);

    // A deadzone of exactly one still lets -1.0 through; anything larger does not.
    wait_drain();
    write_register(REG_DEADZONE, (3*CW)'(32768));
    send_throttle(-32768);
    send_throttle(32767);
    wait_drain();
    write_register(REG_DEADZONE, (3*CW)'(65535));
    send_throttle(-32768);

    // Curves far outside the pulse range saturate at both ends.
    wait_drain();
    write_register(REG_DEADZONE, '0);
    write_register(REG_FWD_LO, pack_curve(0, 0, 32767));
    write_register(REG_FWD_HI, pack_curve(0, 0, 32767));
    write_register(REG_BWD_LO, pack_curve(0, 0, -32768));
    write_register(REG_BWD_HI, pack_curve(0, 0, -32768));
    send_throttle(100);
    send_throttle(-100);
  endtask

  // Random words in chunks, with fresh register values before each chunk.
  task automatic test_random_phase(input int send_pct, input int recv_pct, input int chunks);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (chunks) begin
      random_settings();
      repeat (CHUNK_ITEMS) random_word();
    end
  endtask

  // The receiver holds off for a long stretch while throttle words keep coming, so the
  // output register fills and the block stalls its input. Then the sender pauses until
  // every result is back before it carries on.
  task automatic test_output_backpressure();
    random_settings();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_requests <= stall_requests + 1;
    repeat (40) send_throttle($urandom_range(65535));
    wait_drain();
    repeat (20) random_word();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_directed_cases();
    test_random_phase(20, 84, 4);
    test_random_phase(84, 20, 4);
    test_random_phase(0, 0, 4);
    test_output_backpressure();
    wait_drain();
    $display("Sent %0d input words and checked %0d pulse widths over %0d register settings,",
             words_sent, pulses_checked, settings_used);
    $display("with skewed, reversed and no idling on both sides and one long output stall.");
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bctp_pkg.sv
rtl/battery_compensated_throttle_to_pwm.sv
rtl/bctp_checker.sv
test/battery_compensated_throttle_to_pwm_test.sv
